[rtl/chw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chw_pkg: shared types and constants of the client heartbeat watchdog
// Holds the payload structs, the result status codes and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package chw_pkg;

  localparam int MAX_SLOTS     = 8;
  localparam int NAME_BYTES    = 32;
  localparam int NAME_WORDS    = 4;
  localparam int NAME_BITS     = 64 * NAME_WORDS;
  localparam int SLOT_W        = $clog2(MAX_SLOTS);
  localparam int CNT_W         = $clog2(MAX_SLOTS + 1);
  localparam int TMO_W         = 16;
  localparam int AGE_W         = 17;
  localparam logic [TMO_W-1:0] RESET_TIMEOUT = 16'd120;
  localparam logic [AGE_W-1:0] AGE_MAX       = {AGE_W{1'b1}};

  // Result status codes.
  localparam logic [1:0] STAT_TICK   = 2'd0;
  localparam logic [1:0] STAT_KICK   = 2'd1;
  localparam logic [1:0] STAT_REG    = 2'd2;
  localparam logic [1:0] STAT_REJECT = 2'd3;

  // Name bits kept: the last byte position is reserved for the terminator.
  localparam logic [NAME_BITS-1:0] NAME_MASK =
      {{(NAME_BITS - 8 * (NAME_BYTES - 1)){1'b0}}, {(8 * (NAME_BYTES - 1)){1'b1}}};

  typedef struct packed {
    logic        func;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [63:0] name_word3;
    logic [15:0] timeout_req;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] client_slot;
    logic       keepalive;
    logic       expired;
    logic [3:0] client_total;
  } result_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic kick;
    logic regist;
    logic reject;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic name_zero;
    logic empty;
    logic full;
    logic match;
    logic last;
  } dp_stat_t;

endpackage

[rtl/chw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chw_ctrl: sequencing state machine
// Dispatches each accepted word and walks the client table one slot at a
// time, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module chw_ctrl import chw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DISP = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_CMP  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_tick) begin
          cmd.tick   = 1'b1;
          state_next = S_IDLE;
        end else if (stat.name_zero) begin
          cmd.reject = 1'b1;
          state_next = S_IDLE;
        end else if (stat.empty) begin
          cmd.regist = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.match) begin
          cmd.kick   = 1'b1;
          state_next = S_IDLE;
        end else if (stat.last) begin
          cmd.regist = !stat.full;
          cmd.reject = stat.full;
          state_next = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/chw_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chw_datapath: client table, age lanes and result register
// Holds the name memory, per-slot timeouts and ages, the client count, the
// expiry latch and the default timeout register.
// ----------------------------------------------------------------------------
module chw_datapath import chw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  logic             cfg_we,
  input  logic [TMO_W-1:0] cfg_data,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output result_t          result,
  output logic             done
);

  logic [NAME_BITS-1:0] name_mem [MAX_SLOTS];
  logic [NAME_BITS-1:0] rd_row;
  logic [NAME_BITS-1:0] name_q;
  logic [TMO_W-1:0]     tmo_req_q;
  logic                 func_q;

  logic [TMO_W-1:0]     tmo [MAX_SLOTS];
  logic [AGE_W-1:0]     age [MAX_SLOTS];
  logic [AGE_W-1:0]     age_inc [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] over;

  logic [SLOT_W-1:0]    idx;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 latch;
  logic                 latch_next;
  logic [TMO_W-1:0]     dflt_tmo;
  logic [SLOT_W-1:0]    new_slot;
  logic [TMO_W-1:0]     new_tmo;
  logic                 finish;

  assign new_slot = count[SLOT_W-1:0];
  assign new_tmo  = (tmo_req_q == '0) ? dflt_tmo : tmo_req_q;
  assign finish   = cmd.tick | cmd.kick | cmd.regist | cmd.reject;

  // Each lane ages its own slot on a tick; only registered slots count.
  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      age_inc[s] = (age[s] != AGE_MAX) ? age[s] + 1'b1 : age[s];
      over[s]    = (CNT_W'(s) < count) && (age_inc[s] > {1'b0, tmo[s]});
    end
  end

  assign latch_next = latch | (cmd.tick & (|over));
  assign count_next = cmd.regist ? count + 1'b1 : count;

  assign stat.is_tick   = func_q;
  assign stat.name_zero = (name_q == '0);
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_W'(MAX_SLOTS));
  assign stat.match     = (rd_row == name_q);
  assign stat.last      = ({1'b0, idx} + 1'b1 >= count);

  // Name memory: one row per slot, registered read.
  always_ff @(posedge clk) begin
    if (cmd.regist) begin
      name_mem[new_slot] <= name_q;
    end
    rd_row <= name_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      name_q    <= {item.name_word3, item.name_word2, item.name_word1, item.name_word0}
                   & NAME_MASK;
      tmo_req_q <= item.timeout_req;
      func_q    <= item.func;
    end
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (cmd.tick) begin
        age[s] <= age_inc[s];
      end
    end
    if (cmd.kick) begin
      age[idx] <= '0;
    end
    if (cmd.regist) begin
      age[new_slot] <= '0;
      tmo[new_slot] <= new_tmo;
    end
    if (finish) begin
      result.status       <= cmd.tick   ? STAT_TICK :
                             cmd.kick   ? STAT_KICK :
                             cmd.regist ? STAT_REG  : STAT_REJECT;
      result.client_slot  <= cmd.kick ? idx : (cmd.regist ? new_slot : '0);
      result.keepalive    <= cmd.tick & !latch_next;
      result.expired      <= latch_next;
      result.client_total <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      count    <= '0;
      latch    <= 1'b0;
      done     <= 1'b0;
      dflt_tmo <= RESET_TIMEOUT;
    end else begin
      done  <= finish;
      count <= count_next;
      latch <= latch_next;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (cfg_we) begin
        dflt_tmo <= cfg_data;
      end
    end
  end

endmodule

[rtl/client_heartbeat_watchdog_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_heartbeat_watchdog_core: supervisor for up to eight named clients
// Tracks client heartbeats and one-second ticks and gates the keepalive to a
// hardware watchdog once any client has overrun its timeout.
// ----------------------------------------------------------------------------
// Usage. A command word (item) is taken at a rising edge where start is high
// and busy is low. Every command gives exactly one result word on result,
// shown for a single cycle while done is high; the receiver cannot hold it
// off and must capture it in that cycle.
// A tick word is dispatched, then all eight age lanes update in parallel. A
// heartbeat word finishes at dispatch when it is rejected for an empty name
// or lands in an empty table; otherwise the table is searched slot by slot,
// with one name memory read and one compare per slot searched, through the
// single read port of the name memory.
// The next word may be started in the cycle in which done is high.
// The default timeout register is written through cfg_valid/cfg_ready/
// cfg_data; cfg_ready is always high, and writes belong between commands.
// Synchronous reset empties the table, clears the expiry latch, restores a
// default timeout of 120 seconds and leaves the block idle at once; there is
// no clearing pass, since only registered slots are ever read.
// ----------------------------------------------------------------------------
module client_heartbeat_watchdog_core import chw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  output logic             done,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TMO_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The register can always be taken; the user must write it only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  chw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  chw_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result),
    .done     (done)
  );

endmodule

[rtl/chw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chw_checker: port-level checks for the heartbeat watchdog
// Watches the top-level ports and flags sequencing or result slips.
// ----------------------------------------------------------------------------
module chw_checker import chw_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // An accepted word always makes the block busy in the next cycle, with no result yet.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not make the block busy");

  // Every command passes through dispatch before its result, so results never follow back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.client_total <= 4'(MAX_SLOTS)))
    else $error("client total beyond table size");

  // Keepalive only on a tick, and then exactly when not expired.
  a_keepalive: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.keepalive == ((result.status == STAT_TICK) && !result.expired)))
    else $error("keepalive inconsistent with status and expiry");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STAT_TICK || result.status == STAT_REJECT))
      |-> (result.client_slot == '0))
    else $error("slot reported on a tick or rejected word");

endmodule

bind client_heartbeat_watchdog_core chw_checker u_chw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the client heartbeat watchdog core
// Drives heartbeat and tick command words, keeps its own copy of the client
// table to predict every result word, and compares each strobed result field
// by field. Directed cases cover the special cases of the table and the
// expiry latch; a long random part then works a small pool of client names.
// ----------------------------------------------------------------------------
module tb_top;
  import chw_pkg::*;

  // Run limit in clock cycles, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;
  // Name bits that take part in a compare: the last byte is the terminator.
  localparam logic [255:0] KEPT_NAME_BITS = {8'h00, {31{8'hFF}}};

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  item_t            item;
  logic             done;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [TMO_W-1:0] cfg_data;

  client_heartbeat_watchdog_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predicted client table, mirroring what the core should hold.
  logic [255:0]     roster_name [MAX_SLOTS];
  logic [TMO_W-1:0] roster_tmo  [MAX_SLOTS];
  logic [AGE_W-1:0] roster_age  [MAX_SLOTS];
  int               roster_count;
  logic             expiry_seen;
  logic [TMO_W-1:0] fallback_tmo;

  // Result words owed by the core, oldest first.
  result_t          expected_results [$];
  result_t          due;
  int               faults;
  int               cycles;
  bit               gaps_on;
  logic [255:0]     name_pool [12];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one command word to the predicted table and returns the result
  // word that the core must give for it.
  function automatic result_t supervise(input item_t w);
    result_t      r;
    logic [255:0] nm;
    int           hit;
    r   = '0;
    hit = -1;
    if (w.func) begin
      // A tick ages every registered client; the age stops at its maximum.
      for (int s = 0; s < roster_count; s++) begin
        if (roster_age[s] != AGE_MAX) roster_age[s] = roster_age[s] + 1'b1;
        if (roster_age[s] > {1'b0, roster_tmo[s]}) expiry_seen = 1'b1;
      end
      r.status    = STAT_TICK;
      r.keepalive = !expiry_seen;
    end else begin
      nm = {w.name_word3, w.name_word2, w.name_word1, w.name_word0} & KEPT_NAME_BITS;
      for (int s = 0; s < roster_count; s++) begin
        if (hit < 0 && roster_name[s] == nm) hit = s;
      end
      if (nm == '0) begin
        r.status = STAT_REJECT;
      end else if (hit >= 0) begin
        roster_age[hit] = '0;
        r.status        = STAT_KICK;
        r.client_slot   = hit[2:0];
      end else if (roster_count >= MAX_SLOTS) begin
        r.status = STAT_REJECT;
      end else begin
        roster_name[roster_count] = nm;
        roster_tmo[roster_count]  = (w.timeout_req == '0) ? fallback_tmo : w.timeout_req;
        roster_age[roster_count]  = '0;
        r.client_slot             = roster_count[2:0];
        r.status                  = STAT_REG;
        roster_count++;
      end
    end
    r.expired      = expiry_seen;
    r.client_total = roster_count[3:0];
    return r;
  endfunction

  // Sends one command word. An optional idle gap comes first; start is left
  // high afterwards so that a following word can go out with no bubble, and
  // every caller either sends again or lowers start before time moves on.
  task automatic send_word(input item_t w);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(supervise(w));
  endtask

  task automatic heartbeat(input logic [255:0] nm, input logic [TMO_W-1:0] tmo);
    item_t w;
    w.func        = 1'b0;
    w.name_word0  = nm[63:0];
    w.name_word1  = nm[127:64];
    w.name_word2  = nm[191:128];
    w.name_word3  = nm[255:192];
    w.timeout_req = tmo;
    send_word(w);
  endtask

  // The name and timeout fields of a tick are filled with noise: the core
  // must ignore them.
  task automatic tick();
    item_t w;
    w.func        = 1'b1;
    w.name_word0  = {$urandom, $urandom};
    w.name_word1  = {$urandom, $urandom};
    w.name_word2  = {$urandom, $urandom};
    w.name_word3  = {$urandom, $urandom};
    w.timeout_req = 16'($urandom);
    send_word(w);
  endtask

  // Stops sending and waits until every owed result word has arrived.
  task automatic quiesce();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_default(input logic [TMO_W-1:0] v);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid    <= 1'b0;
    fallback_tmo = v;
  endtask

  function automatic logic [255:0] random_name(input int nbytes);
    logic [255:0] nm;
    nm    = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    nm    = nm & ((256'd1 << (8 * nbytes)) - 1'b1);
    nm[0] = 1'b1;
    return nm;
  endfunction

  // Ticks on an empty table, and names that are empty once the terminator
  // byte is dropped.
  task automatic test_empty_table();
    tick();
    heartbeat('0, 16'd5);
    heartbeat({8'hAB, 248'd0}, 16'd0);
    tick();
    set_default(16'hFFFF);
  endtask

  // Registration with and without a requested timeout, names that differ
  // only after a zero byte, and kicks where the terminator byte is garbage.
  task automatic test_registration();
    name_pool[0] = {256{1'b1}} & KEPT_NAME_BITS;
    name_pool[1] = 256'h61;
    name_pool[2] = 256'h62_0061;
    name_pool[3] = random_name(31);
    name_pool[4] = random_name(8);
    heartbeat({256{1'b1}}, 16'd0);
    heartbeat(name_pool[1], 16'hFFFF);
    heartbeat(name_pool[2], 16'd1);
    heartbeat(name_pool[0], 16'd7);
    set_default(16'd1);
    heartbeat(name_pool[3], 16'd0);
    heartbeat({8'h5A, name_pool[1][247:0]}, 16'd0);
  endtask

  // Clients with a timeout of one survive a single tick but, with a default
  // of zero, a new client expires on its first tick. The latch then stays
  // set while heartbeats go on being handled.
  task automatic test_expiry();
    tick();
    heartbeat(name_pool[2], 16'd0);
    heartbeat(name_pool[3], 16'd9);
    tick();
    set_default(16'd0);
    heartbeat(name_pool[4], 16'd0);
    tick();
    heartbeat(name_pool[0], 16'd0);
    tick();
  endtask

  // Random mix over a pool of names, so that the table fills, known clients
  // get kicked and unknown ones are turned away once it is full. The last
  // chunk runs without idle gaps.
  task automatic test_random_traffic();
    logic [255:0]     nm;
    logic [TMO_W-1:0] tmo;
    int               pick;
    for (int p = 5; p < 12; p++) name_pool[p] = random_name($urandom_range(1, 31));
    for (int chunk = 0; chunk < 4; chunk++) begin
      case (chunk)
        0:       set_default(16'($urandom_range(1, 16'hFFFE)));
        1:       set_default(16'hFFFF);
        2:       set_default(16'($urandom));
        default: set_default(16'd1);
      endcase
      gaps_on = (chunk < 3);
      for (int n = 0; n < 250; n++) begin
        case ($urandom_range(0, 3))
          0:       tmo = '0;
          1:       tmo = 16'hFFFF;
          default: tmo = 16'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          tick();
        end else begin
          if (pick < 80) begin
            nm = name_pool[$urandom_range(0, 11)];
            nm[255:248] = 8'($urandom_range(0, 255));
          end else if (pick < 92) begin
            nm = {$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
          end else begin
            nm = '0;
            if ($urandom_range(0, 1)) nm[255:248] = 8'($urandom_range(1, 255));
          end
          heartbeat(nm, tmo);
        end
      end
    end
  endtask

  // Result checker: every strobed word is matched against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result word: status %0d", result.status);
      end else begin
        due = expected_results.pop_front();
        if (result.status !== due.status || result.client_slot !== due.client_slot ||
            result.keepalive !== due.keepalive || result.expired !== due.expired ||
            result.client_total !== due.client_total) begin
          faults++;
          if (faults <= 10)
            $display({"mismatch: status %0d/%0d slot %0d/%0d keepalive %0d/%0d",
                      " expired %0d/%0d total %0d/%0d (expected/actual)"},
                     due.status, result.status, due.client_slot, result.client_slot,
                     due.keepalive, result.keepalive,
                     due.expired, result.expired, due.client_total, result.client_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    faults       = 0;
    cycles       = 0;
    gaps_on      = 1'b1;
    roster_count = 0;
    expiry_seen  = 1'b0;
    fallback_tmo = RESET_TIMEOUT;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_registration();
    test_expiry();
    test_random_traffic();
    quiesce();
    repeat (20) @(posedge clk);
    if (faults == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/chw_pkg.sv
rtl/chw_ctrl.sv
rtl/chw_datapath.sv
rtl/client_heartbeat_watchdog_core.sv
rtl/chw_checker.sv
test/tb_top.sv
